// ----- src/bhsc_pkg.sv -----
// shared types and constants of the binned histogram core
`default_nettype none

package bhsc_pkg;

	// default sizes of the core
	localparam int MAX_BINS_DEF   = 64;
	localparam int MAX_CATS_DEF   = 16;
	localparam int COUNT_W_DEF    = 32;

	// register values after reset, clamped to the sizes in the core
	localparam int BINS_RESET     = 64;
	localparam int SUBS_RESET     = 16;

	// port widths
	localparam int REQ_W          = 2;
	localparam int INDEX_W        = 7;
	localparam int VALUE_W        = 32;
	localparam int CAT_W          = 5;
	localparam int BIN_OUT_W      = 6;
	localparam int CNT_OUT_W      = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBS_IN_USE = 2'd1;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_EDGE = 2'd0,
		REQ_ADD       = 2'd1,
		REQ_READ      = 2'd2,
		REQ_CLEAR     = 2'd3
	} req_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CNT_RD,
		ST_CNT_UPD,
		ST_SUB_UPD,
		ST_SWEEP,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ----- src/binned_histogram_with_subcounts_core.sv -----
// top level of the binned histogram core with per-category sub-counts
`default_nettype none

// Histogram core: software loads bin edges (signed Q16.16) into an edge ram, then
// add requests find the highest bin in 1..bins_in_use-1 whose lower edge lies
// below the sample (else bin 0) and bump that bin's count, the category's count
// for the bin, and the saturating total; min and max samples are tracked too.
// One request is worked on at a time. The edge ram has one read port and the
// bin search walks it downward one edge per cycle from the top bin, stopping at
// the first edge below the sample or after the edge of bin 1 (no search when one
// bin is in use); the add then reads and updates the bin count, and the category
// count too when its category is valid. Bin and category counts share one count
// ram, updated read-modify-write; a read of a bin in use passes through the same
// read and update states without writing, a read past the bins in use and an
// edge load go straight to the response. A clear, and also reset, runs a clearing
// pass over the whole count ram of (MAX_CATEGORIES+1) * 2**clog2(MAX_BINS)
// entries (1088 at the defaults), one entry a cycle, during which no request is
// taken; configuration writes are taken at any time. A finished response waits
// in an output register while the next request is already at work.
module binned_histogram_with_subcounts_core #(
	parameter int MAX_BINS       = bhsc_pkg::MAX_BINS_DEF,
	parameter int MAX_CATEGORIES = bhsc_pkg::MAX_CATS_DEF,
	parameter int COUNT_WIDTH    = bhsc_pkg::COUNT_W_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bhsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bhsc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire logic [bhsc_pkg::REQ_W-1:0]           req_type,
	input  wire logic [bhsc_pkg::INDEX_W-1:0]         index,
	input  wire logic signed [bhsc_pkg::VALUE_W-1:0]  value,
	input  wire logic signed [bhsc_pkg::CAT_W-1:0]    category,
	// response channel
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output logic [bhsc_pkg::BIN_OUT_W-1:0]            bin,
	output logic [bhsc_pkg::CNT_OUT_W-1:0]            bin_count,
	output logic [bhsc_pkg::CNT_OUT_W-1:0]            sub_bin_count,
	output logic [bhsc_pkg::CNT_OUT_W-1:0]            total_count,
	output logic signed [bhsc_pkg::VALUE_W-1:0]       least_seen,
	output logic signed [bhsc_pkg::VALUE_W-1:0]       greatest_seen
);

	import bhsc_pkg::*;

	localparam int BIN_W     = $clog2(MAX_BINS);
	localparam int EDGE_AW   = $clog2(MAX_BINS + 1);
	localparam int EDGE_D    = MAX_BINS + 1;
	localparam int BINS_W    = EDGE_AW;
	localparam int ROW_W     = $clog2(MAX_CATEGORIES + 1);
	localparam int SUBS_W    = ROW_W;
	localparam int CNT_AW    = ROW_W + BIN_W;
	localparam int CNT_D     = (MAX_CATEGORIES + 1) * (2 ** BIN_W);
	localparam int BINS_RST  = (BINS_RESET > MAX_BINS) ? MAX_BINS : BINS_RESET;
	localparam int SUBS_RST  = (SUBS_RESET > MAX_CATEGORIES) ? MAX_CATEGORIES : SUBS_RESET;

	localparam logic [ROW_W-1:0]  ROW_BINS  = ROW_W'(MAX_CATEGORIES);
	localparam logic [CNT_AW-1:0] SWEEP_END = CNT_AW'(CNT_D - 1);

	// saturating increment of a count
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		logic [COUNT_WIDTH-1:0] r;
		r = (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
		return r;
	endfunction

	// state
	state_t                     state_q, state_d;
	req_t                       req_q;
	logic signed [VALUE_W-1:0]  val_q;
	logic                       cat_ok_q;
	logic [ROW_W-1:0]           cat_q;
	logic [BIN_W-1:0]           bin_q;
	logic [BIN_W-1:0]           scan_idx_q;
	logic [COUNT_WIDTH-1:0]     bc_q;
	logic [COUNT_WIDTH-1:0]     sc_q;
	logic [CNT_AW-1:0]          sweep_q;
	logic                       clr_reply_q;
	logic [COUNT_WIDTH-1:0]     total_q;
	logic signed [VALUE_W-1:0]  min_q;
	logic signed [VALUE_W-1:0]  max_q;
	logic [BINS_W-1:0]          bins_q;
	logic [SUBS_W-1:0]          subs_q;
	logic                       rsp_valid_q;
	logic [BIN_OUT_W-1:0]       rsp_bin_q;
	logic [CNT_OUT_W-1:0]       rsp_bc_q;
	logic [CNT_OUT_W-1:0]       rsp_sc_q;
	logic [CNT_OUT_W-1:0]       rsp_total_q;
	logic signed [VALUE_W-1:0]  rsp_min_q;
	logic signed [VALUE_W-1:0]  rsp_max_q;

	// ram ports
	logic                       edge_we;
	logic [EDGE_AW-1:0]         edge_waddr;
	logic [EDGE_AW-1:0]         edge_raddr;
	logic [VALUE_W-1:0]         edge_rdata;
	logic                       cnt_we;
	logic [CNT_AW-1:0]          cnt_waddr;
	logic [COUNT_WIDTH-1:0]     cnt_wdata;
	logic [CNT_AW-1:0]          cnt_raddr;
	logic [COUNT_WIDTH-1:0]     cnt_rdata;

	// handshakes and decoded request fields
	logic                       req_fire;
	logic                       cfg_fire;
	logic                       rsp_load;
	req_t                       req_in;
	logic                       cat_ok;
	logic                       read_ok;
	logic                       scan_hit;
	logic                       is_add;
	logic [BINS_W-1:0]          bins_m1;
	logic [EDGE_AW+INDEX_W-1:0] idx_edge_ext;
	logic [BIN_W+INDEX_W-1:0]   idx_bin_ext;
	logic [ROW_W+4-1:0]         cat_ext;
	logic [EDGE_AW+BIN_W-1:0]   scan_ext;
	logic [BIN_W+BIN_OUT_W-1:0] bin_ext;
	logic [COUNT_WIDTH+CNT_OUT_W-1:0] bc_ext;
	logic [COUNT_WIDTH+CNT_OUT_W-1:0] sc_ext;
	logic [COUNT_WIDTH+CNT_OUT_W-1:0] total_ext;
	logic [BINS_W+CFG_DATA_W-1:0]     cfg_bins_ext;
	logic [SUBS_W+CAT_W-1:0]          cfg_subs_ext;
	logic [BINS_W-1:0]          cfg_bins;
	logic [SUBS_W-1:0]          cfg_subs;

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign req_fire  = req_valid & req_ready;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign req_in    = req_t'(req_type);
	assign is_add    = (req_q == REQ_ADD);
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

	// field widening and narrowing
	assign idx_edge_ext = {{EDGE_AW{1'b0}}, index};
	assign idx_bin_ext  = {{BIN_W{1'b0}}, index};
	assign cat_ext      = {{ROW_W{1'b0}}, category[3:0]};
	assign bins_m1      = bins_q - BINS_W'(1);
	assign scan_ext     = {{EDGE_AW{1'b0}}, scan_idx_q - BIN_W'(1)};
	assign bin_ext      = {{BIN_OUT_W{1'b0}}, bin_q};
	assign bc_ext       = {{CNT_OUT_W{1'b0}}, bc_q};
	assign sc_ext       = {{CNT_OUT_W{1'b0}}, sc_q};
	assign total_ext    = {{CNT_OUT_W{1'b0}}, total_q};

	// category in range and read index in range
	assign cat_ok  = !category[CAT_W-1] && (int'(category[3:0]) < int'(subs_q));
	assign read_ok = int'(index) < int'(bins_q);

	// sample compared with the edge whose read data is back
	assign scan_hit = ($signed(edge_rdata) < val_q);

	// configuration values clamped to their range
	assign cfg_bins_ext = {{BINS_W{1'b0}}, cfg_data};
	assign cfg_subs_ext = {{SUBS_W{1'b0}}, cfg_data[CAT_W-1:0]};
	assign cfg_bins = (cfg_data == '0) ? BINS_W'(1) :
		(int'(cfg_data) > MAX_BINS) ? BINS_W'(MAX_BINS) : cfg_bins_ext[BINS_W-1:0];
	assign cfg_subs = (cfg_data[CAT_W-1:0] == '0) ? SUBS_W'(1) :
		(int'(cfg_data[CAT_W-1:0]) > MAX_CATEGORIES) ? SUBS_W'(MAX_CATEGORIES) :
		cfg_subs_ext[SUBS_W-1:0];

	// edge table
	bhsc_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (EDGE_D)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (value),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// bin counts in the top row, category counts below it
	bhsc_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (CNT_D)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram controls
	always_comb begin
		state_d    = state_q;
		edge_we    = 1'b0;
		edge_waddr = idx_edge_ext[EDGE_AW-1:0];
		edge_raddr = bins_m1;
		cnt_we     = 1'b0;
		cnt_waddr  = {ROW_BINS, bin_q};
		cnt_wdata  = sat_inc(cnt_rdata);
		cnt_raddr  = {ROW_BINS, bin_q};
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req_in)
						REQ_LOAD_EDGE: begin
							edge_we = (int'(index) <= MAX_BINS);
							state_d = ST_RESP;
						end
						REQ_ADD: begin
							state_d = (bins_q == BINS_W'(1)) ? ST_CNT_RD : ST_SCAN;
						end
						REQ_READ: begin
							state_d = read_ok ? ST_CNT_RD : ST_RESP;
						end
						REQ_CLEAR: begin
							state_d = ST_SWEEP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				edge_raddr = scan_ext[EDGE_AW-1:0];
				if (scan_hit || scan_idx_q == BIN_W'(1)) begin
					state_d = ST_CNT_RD;
				end
			end
			ST_CNT_RD: begin
				state_d = ST_CNT_UPD;
			end
			ST_CNT_UPD: begin
				cnt_we    = is_add;
				cnt_raddr = {cat_q, bin_q};
				state_d   = cat_ok_q ? ST_SUB_UPD : ST_RESP;
			end
			ST_SUB_UPD: begin
				cnt_we    = is_add;
				cnt_waddr = {cat_q, bin_q};
				state_d   = ST_RESP;
			end
			ST_SWEEP: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_q;
				cnt_wdata = '0;
				if (sweep_q == SWEEP_END) begin
					state_d = clr_reply_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= BINS_W'(BINS_RST);
			subs_q <= SUBS_W'(SUBS_RST);
		end else if (cfg_fire) begin
			if (cfg_index == REG_BINS_IN_USE) begin
				bins_q <= cfg_bins;
			end else if (cfg_index == REG_SUBS_IN_USE) begin
				subs_q <= cfg_subs;
			end
		end
	end

	// total, min and max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (req_fire && req_in == REQ_CLEAR) begin
			total_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (req_fire && req_in == REQ_ADD) begin
			total_q <= sat_inc(total_q);
			if (total_q == '0) begin
				min_q <= value;
				max_q <= value;
			end else if (min_q > value) begin
				min_q <= value;
			end else if (max_q < value) begin
				max_q <= value;
			end
		end
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			clr_reply_q <= 1'b0;
			req_q       <= REQ_LOAD_EDGE;
			cat_ok_q    <= 1'b0;
		end else begin
			if (req_fire) begin
				req_q    <= req_in;
				cat_ok_q <= cat_ok;
				if (req_in == REQ_CLEAR) begin
					sweep_q     <= '0;
					clr_reply_q <= 1'b1;
				end
			end else if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + CNT_AW'(1);
				if (sweep_q == SWEEP_END) begin
					clr_reply_q <= 1'b0;
				end
			end
		end
	end

	// request payload, bin search and count updates
	always_ff @(posedge clk) begin
		if (req_fire) begin
			val_q      <= value;
			cat_q      <= cat_ext[ROW_W-1:0];
			bc_q       <= '0;
			sc_q       <= '0;
			scan_idx_q <= bins_m1[BIN_W-1:0];
			bin_q      <= (req_in == REQ_READ && read_ok) ? idx_bin_ext[BIN_W-1:0] : '0;
		end else begin
			case (state_q)
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q - BIN_W'(1);
					if (scan_hit) begin
						bin_q <= scan_idx_q;
					end
				end
				ST_CNT_UPD: begin
					bc_q <= is_add ? sat_inc(cnt_rdata) : cnt_rdata;
				end
				ST_SUB_UPD: begin
					sc_q <= is_add ? sat_inc(cnt_rdata) : cnt_rdata;
				end
				default: begin
					bc_q <= bc_q;
				end
			endcase
		end
	end

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_bin_q   <= bin_ext[BIN_OUT_W-1:0];
			rsp_bc_q    <= bc_ext[CNT_OUT_W-1:0];
			rsp_sc_q    <= sc_ext[CNT_OUT_W-1:0];
			rsp_total_q <= total_ext[CNT_OUT_W-1:0];
			rsp_min_q   <= min_q;
			rsp_max_q   <= max_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign bin           = rsp_bin_q;
	assign bin_count     = rsp_bc_q;
	assign sub_bin_count = rsp_sc_q;
	assign total_count   = rsp_total_q;
	assign least_seen    = rsp_min_q;
	assign greatest_seen = rsp_max_q;

	// bin count write-back never hits the category entry being read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CNT_UPD && cnt_we) |-> (cnt_waddr != cnt_raddr))
		else $error("count ram write and read collide");

	// search index stays within the bins in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q != '0 && int'(scan_idx_q) < int'(bins_q)))
		else $error("bin search index out of range");

	// total only drops through a clear
	assert property (@(posedge clk) disable iff (!arst_n)
		!(req_fire && req_in == REQ_CLEAR) |=> (total_q >= $past(total_q)))
		else $error("sample total went down without a clear");

	// min never above max once a sample has been added
	assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != '0) |-> (min_q <= max_q))
		else $error("least sample above greatest sample");

endmodule

`default_nettype wire

// ----- src/bhsc_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module bhsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
